>>> src/ils_pkg.sv
// Shared types and constants for the indexed list store.
`timescale 1ns / 1ps

package ils_pkg;

    typedef enum logic [2:0] {
        ACT_READ      = 3'd0,
        ACT_INS_FRONT = 3'd1,
        ACT_INS_BACK  = 3'd2,
        ACT_INS_AT    = 3'd3,
        ACT_DELETE    = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SH_RD,
        S_SH_WR,
        S_PLACE,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic               found;
        logic               applied;
        logic               overflow;
        logic [6:0]         list_length;
    } result_t;

    localparam logic signed [31:0] MISS_VALUE = -32'sd1;
    localparam int LENGTH_W = 7;

endpackage

>>> src/indexed_list_store_core.sv
// Top level of the indexed list store: sequencer, entry store and output register.
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit values behind a valid/ready request
// channel and a valid/ready result channel, one result per request. The list lives in
// a single-port-per-direction memory, so each entry that moves on an insert or delete
// is read, then written back one place over. A read in range goes through S_READ; an
// insert at position p shifts the entries from p to the end up and then places the
// value; a delete at p shifts the entries after p down (none when p is the last);
// rejected or invalid requests go straight to S_DONE. A new request is taken while a
// result waits in the output register.

module indexed_list_store_core
    import ils_pkg::*;
#(
    parameter int CAPACITY = 64,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           action,
    input  logic [6:0]           position,
    input  logic signed [31:0]   item_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [31:0]   read_value,
    output logic                 found,
    output logic                 applied,
    output logic                 overflow,
    output logic [6:0]           list_length
);

    logic               res_valid;
    logic               res_ready;
    result_t            res;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic signed [31:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic signed [31:0] mem_rdata;

    logic               out_valid_reg, out_valid_next;
    result_t            out_reg;

    ils_seq #(.CAPACITY(CAPACITY)) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .position   (position),
        .item_value (item_value),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    ils_mem #(.CAPACITY(CAPACITY)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // load when the register is empty or being drained this cycle
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_value  = out_reg.read_value;
    assign found       = out_reg.found;
    assign applied     = out_reg.applied;
    assign overflow    = out_reg.overflow;
    assign list_length = out_reg.list_length;

endmodule

>>> src/ils_mem.sv
// Entry store: one write port, one registered read port.
`timescale 1ns / 1ps

module ils_mem
    import ils_pkg::*;
#(
    parameter int CAPACITY = 64,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
)
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic signed [31:0]   wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output logic signed [31:0]   rdata
);

    logic signed [31:0] mem [CAPACITY];
    logic signed [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/ils_seq.sv
// Request sequencer: decodes an action, shifts entries through the store and builds the result.
`timescale 1ns / 1ps

module ils_seq
    import ils_pkg::*;
#(
    parameter int CAPACITY = 64,
    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW   = $clog2(CAPACITY + 1),
    localparam int CMPW = (CW > LENGTH_W) ? CW : LENGTH_W
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           action,
    input  logic [6:0]           position,
    input  logic signed [31:0]   item_value,
    output logic                 res_valid,
    input  logic                 res_ready,
    output result_t              res,
    output logic                 mem_we,
    output logic [AW-1:0]        mem_waddr,
    output logic signed [31:0]   mem_wdata,
    output logic                 mem_re,
    output logic [AW-1:0]        mem_raddr,
    input  logic signed [31:0]   mem_rdata
);

    seq_state_t         state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               del_reg, del_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [AW-1:0]      lim_reg, lim_next;
    logic signed [31:0] val_reg, val_next;
    logic signed [31:0] rv_reg, rv_next;
    logic               fnd_reg, fnd_next;
    logic               app_reg, app_next;
    logic               ovf_reg, ovf_next;

    logic [CMPW-1:0]    cnt_ext;
    logic [CMPW-1:0]    pos_ext;
    logic [CMPW-1:0]    ip_ext;
    logic               ins_ok;
    logic [AW-1:0]      step_idx;
    action_t            act;

    assign act     = action_t'(action);
    assign cnt_ext = CMPW'(count_reg);
    assign pos_ext = CMPW'(position);

    always_comb
    begin
        ip_ext = '0;
        ins_ok = 1'b1;
        case (act)
            ACT_INS_BACK: ip_ext = cnt_ext;
            ACT_INS_AT:
            begin
                ip_ext = pos_ext;
                ins_ok = (pos_ext <= cnt_ext);
            end
            default: ip_ext = '0;
        endcase
    end

    assign step_idx = del_reg ? (idx_reg + AW'(1)) : (idx_reg - AW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        del_reg <= del_next;
        idx_reg <= idx_next;
        lim_reg <= lim_next;
        val_reg <= val_next;
        rv_reg  <= rv_next;
        fnd_reg <= fnd_next;
        app_reg <= app_next;
        ovf_reg <= ovf_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        del_next   = del_reg;
        idx_next   = idx_reg;
        lim_next   = lim_reg;
        val_next   = val_reg;
        rv_next    = rv_reg;
        fnd_next   = fnd_reg;
        app_next   = app_reg;
        ovf_next   = ovf_reg;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg;
        mem_wdata  = mem_rdata;
        mem_re     = 1'b0;
        mem_raddr  = step_idx;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    rv_next  = '0;
                    fnd_next = 1'b0;
                    app_next = 1'b0;
                    ovf_next = 1'b0;
                    val_next = item_value;
                    del_next = (act == ACT_DELETE);
                    state_next = S_DONE;
                    unique case (act) inside
                        ACT_READ:
                        begin
                            if (pos_ext < cnt_ext)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(position);
                                state_next = S_READ;
                            end
                            else
                            begin
                                rv_next = MISS_VALUE;
                            end
                        end
                        ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT:
                        begin
                            if (ins_ok)
                            begin
                                if (cnt_ext == CMPW'(CAPACITY))
                                begin
                                    ovf_next = 1'b1;
                                end
                                else
                                begin
                                    lim_next = AW'(ip_ext);
                                    idx_next = AW'(count_reg);
                                    state_next = (cnt_ext == ip_ext) ? S_PLACE : S_SH_RD;
                                end
                            end
                        end
                        ACT_DELETE:
                        begin
                            if (pos_ext < cnt_ext)
                            begin
                                idx_next = AW'(position);
                                lim_next = AW'(count_reg - CW'(1));
                                if ((pos_ext + CMPW'(1)) == cnt_ext)
                                begin
                                    count_next = count_reg - CW'(1);
                                    app_next   = 1'b1;
                                end
                                else
                                begin
                                    state_next = S_SH_RD;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                rv_next    = mem_rdata;
                fnd_next   = 1'b1;
                state_next = S_DONE;
            end
            S_SH_RD:
            begin
                // fetch the neighbour that moves into idx
                mem_re     = 1'b1;
                mem_raddr  = step_idx;
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = mem_rdata;
                idx_next  = step_idx;
                if (step_idx == lim_reg)
                begin
                    if (del_reg)
                    begin
                        count_next = count_reg - CW'(1);
                        app_next   = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_PLACE;
                    end
                end
                else
                begin
                    state_next = S_SH_RD;
                end
            end
            S_PLACE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = lim_reg;
                mem_wdata  = val_reg;
                count_next = count_reg + CW'(1);
                app_next   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb
    begin
        res.read_value  = rv_reg;
        res.found       = fnd_reg;
        res.applied     = app_reg;
        res.overflow    = ovf_reg;
        res.list_length = cnt_ext[LENGTH_W-1:0];
    end

endmodule

>>> src/ils_checker.sv
// Port-level checks for the indexed list store, bound to the top level.
`timescale 1ns / 1ps

module ils_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic signed [31:0]  read_value,
    input logic                found,
    input logic                applied,
    input logic                overflow,
    input logic [6:0]          list_length
);

    // in_ready is low in the cycle after a request is taken, so requests are never taken back to back
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
    else $error("request taken on back-to-back cycles");

    // a read hit never reports a list change or a drop
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (!applied && !overflow && list_length != 7'd0))
    else $error("read hit with inconsistent flags");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && applied) |-> !overflow)
    else $error("transaction both applied and dropped");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(read_value)
                                       && $stable(list_length)))
    else $error("stalled result changed");

endmodule

bind indexed_list_store_core ils_checker u_chk (.*);

>>> tb/indexed_list_store_checker.sv
// Checker for the indexed list store: tracks the list contents, predicts each result and compares.
`timescale 1ns / 1ps

module indexed_list_store_checker
    import ils_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [2:0]         action,
    input  logic [6:0]         position,
    input  logic signed [31:0] item_value,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] read_value,
    input  logic               found,
    input  logic               applied,
    input  logic               overflow,
    input  logic [6:0]         list_length,
    output int                 mismatch_count,
    output int                 pending_results,
    output int                 held_count
);

    logic signed [31:0] held_values [CAPACITY];
    result_t            predicted_results [$];
    result_t            oldest;

    initial
    begin
        mismatch_count  = 0;
        pending_results = 0;
        held_count      = 0;
    end

    task automatic apply_list_request(input logic [2:0] act, input logic [6:0] pos,
                                      input logic signed [31:0] val);
        result_t r;
        int      slot;
        int      i;
        int      pos_i;
        bit      do_insert;
        r         = '0;
        slot      = 0;
        pos_i     = int'(pos);
        do_insert = 1'b0;
        case (act)
            ACT_READ:
            begin
                if (pos_i < held_count)
                begin
                    r.read_value = held_values[pos_i];
                    r.found      = 1'b1;
                end
                else
                    r.read_value = MISS_VALUE;
            end
            ACT_INS_FRONT:
            begin
                slot      = 0;
                do_insert = 1'b1;
            end
            ACT_INS_BACK:
            begin
                slot      = held_count;
                do_insert = 1'b1;
            end
            ACT_INS_AT:
            begin
                // beyond the end is ignored, at the end appends
                if (pos_i <= held_count)
                begin
                    slot      = pos_i;
                    do_insert = 1'b1;
                end
            end
            ACT_DELETE:
            begin
                if (pos_i < held_count)
                begin
                    for (i = pos_i; i + 1 < held_count; i++)
                        held_values[i] = held_values[i + 1];
                    held_count--;
                    r.applied = 1'b1;
                end
            end
            default:
                ;
        endcase
        if (do_insert)
        begin
            if (held_count >= CAPACITY)
                r.overflow = 1'b1;
            else
            begin
                for (i = held_count; i > slot; i--)
                    held_values[i] = held_values[i - 1];
                held_values[slot] = val;
                held_count++;
                r.applied = 1'b1;
            end
        end
        r.list_length = held_count[LENGTH_W-1:0];
        predicted_results.push_back(r);
    endtask

    task automatic compare_field(input string field, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count = 0;
            predicted_results.delete();
            pending_results = 0;
        end
        else
        begin
            // a result never belongs to the request taken at the same edge
            if (out_valid && out_ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result transaction expected none, got read_value %0d %s %0d",
                             $time, read_value, "list_length", list_length);
                end
                else
                begin
                    oldest = predicted_results.pop_front();
                    compare_field("read_value", oldest.read_value, read_value);
                    compare_field("found", 32'(oldest.found), 32'(found));
                    compare_field("applied", 32'(oldest.applied), 32'(applied));
                    compare_field("overflow", 32'(oldest.overflow), 32'(overflow));
                    compare_field("list_length", 32'(oldest.list_length), 32'(list_length));
                end
            end
            if (in_valid && in_ready)
                apply_list_request(action, position, item_value);
            pending_results = predicted_results.size();
        end
    end

endmodule

>>> tb/indexed_list_store_core_tb.sv
// Top of the indexed list store testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module indexed_list_store_core_tb
    import ils_pkg::*;
;

    localparam int         CAPACITY     = 64;
    localparam int         CLK_HALF     = 4;
    localparam int         CYCLE_LIMIT  = 1000000;
    localparam int         SETTLE_CYCLES = 200;
    localparam logic [2:0] ACT_UNUSED   = 3'd7;

    typedef enum int { MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_NOISE } request_mix_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         action;
    logic [6:0]         position;
    logic signed [31:0] item_value;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] read_value;
    logic               found;
    logic               applied;
    logic               overflow;
    logic [6:0]         list_length;

    int mismatch_count;
    int pending_results;
    int held_count;
    int gap_pct;
    int stall_pct;
    int cycle_count;

    indexed_list_store_core #(.CAPACITY(CAPACITY)) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .position    (position),
        .item_value  (item_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_value  (read_value),
        .found       (found),
        .applied     (applied),
        .overflow    (overflow),
        .list_length (list_length)
    );

    indexed_list_store_checker #(.CAPACITY(CAPACITY)) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .position        (position),
        .item_value      (item_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .read_value      (read_value),
        .found           (found),
        .applied         (applied),
        .overflow        (overflow),
        .list_length     (list_length),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .held_count      (held_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // Receiver: drop ready in short bursts
    initial
    begin
        out_ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(99) < stall_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction
    task automatic send_request(input logic [2:0] act, input logic [6:0] pos,
                                input logic signed [31:0] val);
        if ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        position   <= pos;
        item_value <= val;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
    endtask

    function automatic logic signed [31:0] random_value();
        case ($urandom_range(15))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return -32'sd1;
            3:       return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_request(input request_mix_t mix);
        int unsigned roll;
        int          len;
        logic [2:0]  act;
        logic [6:0]  pos;
        roll = $urandom_range(99);
        len  = held_count;
        case (mix)
            MIX_FILL:
                act = (roll < 30) ? ACT_INS_AT : (roll < 55) ? ACT_INS_BACK :
                      (roll < 80) ? ACT_INS_FRONT : (roll < 90) ? ACT_READ : ACT_DELETE;
            MIX_DRAIN:
                act = (roll < 65) ? ACT_DELETE : (roll < 80) ? ACT_READ :
                      (roll < 90) ? ACT_INS_AT : (roll < 95) ? ACT_INS_FRONT : ACT_INS_BACK;
            MIX_EVEN:
                act = (roll < 20) ? ACT_READ : (roll < 40) ? ACT_INS_FRONT :
                      (roll < 60) ? ACT_INS_BACK : (roll < 80) ? ACT_INS_AT : ACT_DELETE;
            default:
                act = 3'($urandom_range(7));
        endcase
        // mostly hit the live part of the list, now and then anywhere
        if (mix == MIX_NOISE || $urandom_range(19) == 0)
            pos = 7'($urandom_range(127));
        else if (act == ACT_DELETE && len > 0)
            pos = 7'($urandom_range(len - 1));
        else
            pos = 7'($urandom_range(len));
        send_request(act, pos, random_value());
    endtask

    initial
    begin
        int           i;
        int           phase;
        int           count;
        request_mix_t mix;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        action     = ACT_READ;
        position   = '0;
        item_value = '0;
        gap_pct    = 0;
        stall_pct  = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        gap_pct   = 25;
        stall_pct = 25;
        // empty list: miss, delete ignored, insert beyond the end ignored
        send_request(ACT_READ, 7'd0, 32'sd0);
        send_request(ACT_DELETE, 7'd0, 32'sd0);
        send_request(ACT_INS_AT, 7'd1, 32'sd99);
        send_request(ACT_INS_AT, 7'd0, 32'sh7fffffff);
        send_request(ACT_INS_FRONT, 7'd0, 32'sh80000000);
        send_request(ACT_INS_BACK, 7'd0, -32'sd1);
        send_request(ACT_INS_AT, 7'd3, 32'sd0);
        send_request(ACT_INS_AT, 7'd2, 32'sd12345);
        send_request(ACT_INS_AT, 7'd7, 32'sd5);
        for (i = 0; i < 6; i++)
            send_request(ACT_READ, 7'(i), 32'sd0);
        send_request(ACT_READ, 7'd127, 32'sd0);
        send_request(ACT_DELETE, 7'd127, 32'sd0);
        send_request(ACT_DELETE, 7'd4, 32'sd0);
        send_request(ACT_DELETE, 7'd0, 32'sd0);
        send_request(ACT_DELETE, 7'd1, 32'sd0);
        // stored -1 must read back with found set
        send_request(ACT_READ, 7'd1, 32'sd0);
        send_request(ACT_UNUSED, 7'd0, 32'sd77);
        send_request(ACT_DELETE, 7'd0, 32'sd0);
        send_request(ACT_DELETE, 7'd0, 32'sd0);
        send_request(ACT_READ, 7'd0, 32'sd0);
        wait_until_drained();

        for (phase = 0; phase < 9; phase++)
        begin
            case (phase)
                0:       begin mix = MIX_FILL;  count = 110; gap_pct = 20; stall_pct = 20; end
                1:       begin mix = MIX_EVEN;  count = 200; gap_pct = 0;  stall_pct = 0;  end
                2:       begin mix = MIX_DRAIN; count = 120; gap_pct = 30; stall_pct = 30; end
                3:       begin mix = MIX_EVEN;  count = 250; gap_pct = 15; stall_pct = 40; end
                4:       begin mix = MIX_FILL;  count = 120; gap_pct = 40; stall_pct = 10; end
                5:       begin mix = MIX_NOISE; count = 150; gap_pct = 20; stall_pct = 20; end
                6:       begin mix = MIX_DRAIN; count = 100; gap_pct = 10; stall_pct = 50; end
                7:       begin mix = MIX_FILL;  count = 150; gap_pct = 25; stall_pct = 25; end
                default: begin mix = MIX_EVEN;  count = 150; gap_pct = 0;  stall_pct = 0;  end
            endcase
            repeat (count) send_random_request(mix);
            // hold off until every outstanding result has come back
            wait_until_drained();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
